// ===== hw/rtl/imh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imh_pkg
// Operation and status codes shared by the indexed min-heap unit and its users.
// ----------------------------------------------------------------------------
package imh_pkg;

	// Operation carried by one item.
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_BUILD   = 2'd1,
		OP_INSERT  = 2'd2,
		OP_EXTRACT = 2'd3
	} op_t;

	// Completion status reported with each result.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_RANGE     = 2'd1,
		STATUS_DUPLICATE = 2'd2,
		STATUS_EMPTY     = 2'd3
	} status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/indexed_min_heap_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap_unit
// Indexed binary min-heap kept in three single-port-read memories (keys, heap
// slots with cached keys, position map) and driven by one sequencer.
// One item at a time: busy stays high until the result strobe (an item
//   refused in idle gets its strobe with busy low); the next item may start
//   in the strobe cycle. Results cannot be stalled.
// Reset: the position map is cleared after reset, with busy high;
//   configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module indexed_min_heap_unit #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int KEY_WIDTH    = 32
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      cfg_write,
	input  wire [$clog2(MAX_ELEMENTS+1)-1:0]         element_count,
	input  wire                                      start,
	output logic                                     busy,
	input  imh_pkg::op_t                             op,
	input  wire [$clog2(MAX_ELEMENTS+1)-1:0]         element_index,
	input  wire signed [KEY_WIDTH-1:0]               element_key,
	output logic                                     done,
	output imh_pkg::status_t                         status,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]        min_index,
	output logic signed [KEY_WIDTH-1:0]              min_key,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]        heap_count
);
	import imh_pkg::*;

	localparam int IW = $clog2(MAX_ELEMENTS + 1);
	localparam int DEPTH = MAX_ELEMENTS + 1;
	localparam logic [IW-1:0] MAX_IDX = IW'(MAX_ELEMENTS);

	typedef struct packed {
		logic [IW-1:0]               idx;
		logic signed [KEY_WIDTH-1:0] key;
	} entry_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHK, S_EX_A, S_EX_B, S_BF, S_BF_LAST, S_BH_RD, S_BH_LD,
		S_DN_START, S_DN_RDR, S_DN_CMP, S_UP_START, S_UP_CMP
	} state_t;

	state_t                      state_q;
	logic [IW-1:0]               count_q;
	logic [IW-1:0]               size_q;
	logic [IW-1:0]               fill_q;
	logic [IW-1:0]               slot_q;
	logic [IW-1:0]               node_q;
	logic                        build_q;
	logic                        r_ok_q;
	entry_t                      cur_q;
	entry_t                      left_q;
	entry_t                      root_q;
	op_t                         op_q;
	logic [IW-1:0]               idx_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic                        done_q;
	status_t                     status_q;
	logic [IW-1:0]               min_idx_q;
	logic signed [KEY_WIDTH-1:0] min_key_q;
	logic                        bw_s1;
	logic [IW-1:0]               ba_s1;

	// Memories and their registered read data.
	logic signed [KEY_WIDTH-1:0] key_mem [DEPTH];
	entry_t                      heap_mem [DEPTH];
	logic [IW-1:0]               pos_mem [DEPTH];
	logic signed [KEY_WIDTH-1:0] key_rd;
	entry_t                      heap_rd;
	logic [IW-1:0]               pos_rd;

	logic                        heap_we;
	logic [IW-1:0]               heap_wa;
	entry_t                      heap_wd;
	logic [IW-1:0]               heap_ra;
	logic                        pos_we;
	logic [IW-1:0]               pos_wa;
	logic [IW-1:0]               pos_wd;
	logic                        key_we;

	logic [IW-1:0]               cnt;
	logic [IW:0]                 l_slot;
	logic [IW:0]                 r_slot;
	logic                        has_l;
	logic                        has_r;
	logic                        l_lt;
	logic                        r_lt;
	logic                        moved;
	entry_t                      best0;
	entry_t                      best;
	logic [IW:0]                 best_slot;
	logic                        up_lt;

	// Effective element count, saturated to the table size.
	assign cnt = (count_q > MAX_IDX) ? MAX_IDX : count_q;

	// Child slots and the sift-down choice: strict less, left child first.
	assign l_slot    = {slot_q, 1'b0};
	assign r_slot    = l_slot + 1'b1;
	assign has_l     = l_slot <= {1'b0, size_q};
	assign has_r     = r_slot <= {1'b0, size_q};
	assign l_lt      = left_q.key < cur_q.key;
	assign best0     = l_lt ? left_q : cur_q;
	assign r_lt      = r_ok_q && (heap_rd.key < best0.key);
	assign moved     = l_lt || r_lt;
	assign best      = r_lt ? heap_rd : left_q;
	assign best_slot = r_lt ? r_slot : l_slot;
	assign up_lt     = cur_q.key < heap_rd.key;

	// Memory port control for each sequencer state.
	always_comb begin
		heap_we = 1'b0;
		heap_wa = slot_q;
		heap_wd = cur_q;
		pos_we  = 1'b0;
		pos_wa  = cur_q.idx;
		pos_wd  = slot_q;
		key_we  = 1'b0;
		heap_ra = '0;
		if (bw_s1) begin
			heap_we = 1'b1;
			heap_wa = ba_s1;
			heap_wd = '{idx: ba_s1, key: key_rd};
			pos_we  = 1'b1;
			pos_wa  = ba_s1;
			pos_wd  = (ba_s1 != '0 && ba_s1 <= cnt) ? ba_s1 : '0;
		end
		unique case (state_q)
			S_CLEAR: begin
				pos_we = 1'b1;
				pos_wa = fill_q;
				pos_wd = '0;
			end
			S_IDLE: heap_ra = IW'(1);
			S_CHK: key_we = (pos_rd == '0);
			S_EX_A: heap_ra = size_q;
			S_EX_B: begin
				pos_we = 1'b1;
				pos_wa = root_q.idx;
				pos_wd = '0;
			end
			S_BH_RD: heap_ra = node_q;
			S_DN_START: begin
				heap_ra = l_slot[IW-1:0];
				if (!has_l) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
				end
			end
			S_DN_RDR: heap_ra = has_r ? r_slot[IW-1:0] : '0;
			S_DN_CMP: begin
				heap_we = 1'b1;
				pos_we  = 1'b1;
				if (moved) begin
					heap_wd = best;
					pos_wa  = best.idx;
				end
			end
			S_UP_START: begin
				heap_ra = slot_q >> 1;
				if (slot_q == IW'(1)) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
				end
			end
			S_UP_CMP: begin
				heap_we = 1'b1;
				pos_we  = 1'b1;
				if (up_lt) begin
					heap_wd = heap_rd;
					pos_wa  = heap_rd.idx;
				end
			end
			default: ;
		endcase
	end

	// Synchronous memories with registered read data.
	always_ff @(posedge clk) begin
		if (heap_we) heap_mem[heap_wa] <= heap_wd;
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		if (key_we) key_mem[idx_q] <= key_q;
		heap_rd <= heap_mem[heap_ra];
		pos_rd  <= pos_mem[element_index];
		key_rd  <= key_mem[fill_q];
	end

	// Build fill pipeline: registered write strobe and address that go with the key read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_s1 <= 1'b0;
		end else begin
			bw_s1 <= (state_q == S_BF);
		end
	end

	always_ff @(posedge clk) begin
		ba_s1 <= fill_q;
	end

	// Sequencer with state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			count_q   <= MAX_IDX;
			size_q    <= '0;
			fill_q    <= '0;
			done_q    <= 1'b0;
			status_q  <= STATUS_OK;
			min_idx_q <= '0;
			min_key_q <= '0;
			build_q   <= 1'b0;
			r_ok_q    <= 1'b0;
			slot_q    <= '0;
			node_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_write) begin
				count_q <= element_count;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (fill_q == MAX_IDX) begin
						fill_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q      <= op;
						idx_q     <= element_index;
						key_q     <= element_key;
						status_q  <= STATUS_OK;
						min_idx_q <= '0;
						min_key_q <= '0;
						build_q   <= 1'b0;
						unique case (op)
							OP_LOAD, OP_INSERT: begin
								if (element_index == '0 || element_index > cnt) begin
									status_q <= STATUS_RANGE;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_CHK;
								end
							end
							OP_BUILD: begin
								fill_q  <= '0;
								build_q <= 1'b1;
								state_q <= S_BF;
							end
							default: begin
								if (size_q == '0) begin
									status_q <= STATUS_EMPTY;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_EX_A;
								end
							end
						endcase
					end
				end
				S_CHK: begin
					if (pos_rd != '0) begin
						status_q <= STATUS_DUPLICATE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (op_q == OP_INSERT && size_q != MAX_IDX) begin
						size_q  <= size_q + 1'b1;
						slot_q  <= size_q + 1'b1;
						cur_q   <= '{idx: idx_q, key: key_q};
						state_q <= S_UP_START;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_EX_A: begin
					root_q  <= heap_rd;
					state_q <= S_EX_B;
				end
				S_EX_B: begin
					cur_q     <= heap_rd;
					min_idx_q <= root_q.idx;
					min_key_q <= root_q.key;
					size_q    <= size_q - 1'b1;
					slot_q    <= IW'(1);
					if (size_q == IW'(1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DN_START;
					end
				end
				S_BF: begin
					if (fill_q == MAX_IDX) begin
						state_q <= S_BF_LAST;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				S_BF_LAST: begin
					size_q <= cnt;
					node_q <= cnt >> 1;
					if ((cnt >> 1) == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BH_RD;
					end
				end
				S_BH_RD: state_q <= S_BH_LD;
				S_BH_LD: begin
					cur_q   <= heap_rd;
					slot_q  <= node_q;
					state_q <= S_DN_START;
				end
				S_DN_START: begin
					if (has_l) begin
						state_q <= S_DN_RDR;
					end else if (build_q && node_q != IW'(1)) begin
						node_q  <= node_q - 1'b1;
						state_q <= S_BH_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DN_RDR: begin
					left_q  <= heap_rd;
					r_ok_q  <= has_r;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (moved) begin
						slot_q  <= best_slot[IW-1:0];
						state_q <= S_DN_START;
					end else if (build_q && node_q != IW'(1)) begin
						node_q  <= node_q - 1'b1;
						state_q <= S_BH_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_UP_START: begin
					if (slot_q == IW'(1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (up_lt) begin
						slot_q  <= slot_q >> 1;
						state_q <= S_UP_START;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result ports.
	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign min_index  = min_idx_q;
	assign min_key    = min_key_q;
	assign heap_count = size_q;

`ifndef SYNTH
	// A result is only ever shown with the sequencer back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// An accepted item either keeps the unit busy or yields its result at once.
	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("item dropped");

	// Only a successful extract reports a removed element.
	a_min_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_OK) |-> (min_index == '0 && min_key == '0))
		else $error("min fields set on failure");

	// The heap never grows past its capacity.
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= MAX_IDX) else $error("heap size overflow");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/indexed_min_heap_checker.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_checker
// Watches the configuration, item and result ports of the indexed min-heap
// unit, keeps its own copy of the heap, and compares every result strobe
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module indexed_min_heap_checker #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int KEY_WIDTH    = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_write,
	input  wire [$clog2(MAX_ELEMENTS+1)-1:0]     element_count,
	input  wire                                  start,
	input  wire                                  busy,
	input  imh_pkg::op_t                         op,
	input  wire [$clog2(MAX_ELEMENTS+1)-1:0]     element_index,
	input  wire signed [KEY_WIDTH-1:0]           element_key,
	input  wire                                  done,
	input  imh_pkg::status_t                     status,
	input  wire [$clog2(MAX_ELEMENTS+1)-1:0]     min_index,
	input  wire signed [KEY_WIDTH-1:0]           min_key,
	input  wire [$clog2(MAX_ELEMENTS+1)-1:0]     heap_count,
	output int                                   pending,
	output int                                   errors
);
	import imh_pkg::*;

	localparam int IW = $clog2(MAX_ELEMENTS + 1);

	typedef struct {
		status_t                 st;
		logic [IW-1:0]           idx;
		logic signed [KEY_WIDTH-1:0] key;
		logic [IW-1:0]           cnt;
	} heap_result_t;

	heap_result_t results_due[$];

	// Shadow copy of the heap.
	logic signed [KEY_WIDTH-1:0] key_of [1:MAX_ELEMENTS];
	int slot_elem [1:MAX_ELEMENTS];
	int elem_slot [0:MAX_ELEMENTS];
	int heap_len;
	int count_reg;

	function automatic bit slot_less(int a, int b);
		return key_of[slot_elem[a]] < key_of[slot_elem[b]];
	endfunction

	function automatic void swap_slots(int a, int b);
		int t;
		t = slot_elem[a];
		slot_elem[a] = slot_elem[b];
		slot_elem[b] = t;
		elem_slot[slot_elem[a]] = a;
		elem_slot[slot_elem[b]] = b;
	endfunction

	function automatic void sink(int s);
		int l, r, best;
		forever begin
			l = 2 * s;
			r = l + 1;
			best = s;
			if (l <= heap_len && slot_less(l, best))
				best = l;
			if (r <= heap_len && slot_less(r, best))
				best = r;
			if (best == s)
				return;
			swap_slots(s, best);
			s = best;
		end
	endfunction

	// Applies one heap operation and returns the result it should produce.
	function automatic heap_result_t heap_apply(op_t o, int idx, logic signed [KEY_WIDTH-1:0] k);
		heap_result_t res;
		int cnt, s, root, last;
		cnt = (count_reg > MAX_ELEMENTS) ? MAX_ELEMENTS : count_reg;
		res.st = STATUS_OK;
		res.idx = '0;
		res.key = '0;
		if (o == OP_LOAD || o == OP_INSERT) begin
			if (idx < 1 || idx > cnt) begin
				res.st = STATUS_RANGE;
			end else if (elem_slot[idx] != 0) begin
				res.st = STATUS_DUPLICATE;
			end else begin
				key_of[idx] = k;
				if (o == OP_INSERT && heap_len < MAX_ELEMENTS) begin
					heap_len++;
					slot_elem[heap_len] = idx;
					elem_slot[idx] = heap_len;
					s = heap_len;
					while (s > 1 && slot_less(s, s / 2)) begin
						swap_slots(s, s / 2);
						s = s / 2;
					end
				end
			end
		end else if (o == OP_BUILD) begin
			for (int i = 0; i <= MAX_ELEMENTS; i++)
				elem_slot[i] = 0;
			heap_len = cnt;
			for (int i = 1; i <= cnt; i++) begin
				slot_elem[i] = i;
				elem_slot[i] = i;
			end
			for (int i = cnt / 2; i >= 1; i--)
				sink(i);
		end else begin
			if (heap_len == 0) begin
				res.st = STATUS_EMPTY;
			end else begin
				root = slot_elem[1];
				last = slot_elem[heap_len];
				res.idx = IW'(root);
				res.key = key_of[root];
				slot_elem[1] = last;
				elem_slot[last] = 1;
				elem_slot[root] = 0;
				heap_len--;
				if (heap_len > 0)
					sink(1);
			end
		end
		res.cnt = IW'(heap_len);
		return res;
	endfunction

	// Predict on each accepted item, compare on each result strobe.
	always @(posedge clk or negedge arst_n) begin
		heap_result_t want;
		if (!arst_n) begin
			for (int i = 0; i <= MAX_ELEMENTS; i++)
				elem_slot[i] = 0;
			for (int i = 1; i <= MAX_ELEMENTS; i++) begin
				key_of[i] = '0;
				slot_elem[i] = 0;
			end
			heap_len = 0;
			count_reg = MAX_ELEMENTS;
			results_due.delete();
			errors = 0;
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					$display("%0t: result with nothing expected: status %0d index %0d",
						$time, status, min_index);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
						errors++;
					end
					if (min_index !== want.idx) begin
						$display("%0t: min_index expected %0d actual %0d",
							$time, want.idx, min_index);
						errors++;
					end
					if (min_key !== want.key) begin
						$display("%0t: min_key expected %0d actual %0d", $time, want.key, min_key);
						errors++;
					end
					if (heap_count !== want.cnt) begin
						$display("%0t: heap_count expected %0d actual %0d",
							$time, want.cnt, heap_count);
						errors++;
					end
				end
			end
			if (start && !busy)
				results_due.push_back(heap_apply(op, element_index, element_key));
			if (cfg_write)
				count_reg = element_count;
		end
		pending = results_due.size();
	end

endmodule

// ===== tb/sv/tb_indexed_min_heap_unit.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_unit
// Drives directed and random heap operations into the indexed min-heap unit
// across several element counts and lets the checker judge every result.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_unit;
	import imh_pkg::*;

	localparam int MAXE       = 1024;
	localparam int KW         = 32;
	localparam int IW         = $clog2(MAXE + 1);
	localparam int ITEM_GOAL  = 1800;
	localparam int CYCLE_CAP  = 3000000;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [IW-1:0] element_count;
	logic start;
	logic busy;
	op_t op;
	logic [IW-1:0] element_index;
	logic signed [KW-1:0] element_key;
	logic done;
	status_t status;
	logic [IW-1:0] min_index;
	logic signed [KW-1:0] min_key;
	logic [IW-1:0] heap_count;
	int pending;
	int errors;
	int cycles;

	// Stimulus-side bookkeeping: current count and which keys were written.
	int count_now;
	bit key_written [1:MAXE];
	int items_sent;
	bit idle_enabled;

	indexed_min_heap_unit #(.MAX_ELEMENTS(MAXE), .KEY_WIDTH(KW)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .element_count(element_count),
		.start(start), .busy(busy), .op(op), .element_index(element_index),
		.element_key(element_key), .done(done), .status(status), .min_index(min_index),
		.min_key(min_key), .heap_count(heap_count)
	);

	indexed_min_heap_checker #(.MAX_ELEMENTS(MAXE), .KEY_WIDTH(KW)) u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .element_count(element_count),
		.start(start), .busy(busy), .op(op), .element_index(element_index),
		.element_key(element_key), .done(done), .status(status), .min_index(min_index),
		.min_key(min_key), .heap_count(heap_count), .pending(pending), .errors(errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int usable_count();
		return (count_now > MAXE) ? MAXE : count_now;
	endfunction

	// Presents one item, holds it until accepted, then maybe idles.
	task automatic send_item(op_t o, int idx, logic signed [KW-1:0] k);
		start <= 1'b1;
		op <= o;
		element_index <= IW'(idx);
		element_key <= k;
		if ((o == OP_LOAD || o == OP_INSERT) && idx >= 1 && idx <= usable_count())
			key_written[idx] = 1'b1;
		@(negedge clk);
		while (busy) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		items_sent++;
		if (idle_enabled && $urandom_range(99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Lowers start and waits until every result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		@(negedge clk);
		while (pending != 0) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	task automatic write_count(int v);
		cfg_write <= 1'b1;
		element_count <= IW'(v);
		count_now = v;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Builds only over written keys: missing keys are loaded first.
	task automatic build_safe();
		for (int i = 1; i <= usable_count(); i++)
			if (!key_written[i])
				send_item(OP_LOAD, i, $urandom);
		send_item(OP_BUILD, 0, 0);
	endtask

	function automatic logic signed [KW-1:0] pick_key();
		if ($urandom_range(1))
			return $urandom;
		return $signed($urandom_range(6)) - 3;
	endfunction

	function automatic int pick_index();
		if (usable_count() > 0 && $urandom_range(99) < 90)
			return $urandom_range(1, usable_count());
		return $urandom_range(0, MAXE);
	endfunction

	initial begin
		int roll, span, sel;
		cycles = 0;
		items_sent = 0;
		idle_enabled = 1'b1;
		count_now = MAXE;
		for (int i = 1; i <= MAXE; i++)
			key_written[i] = 1'b0;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		element_count <= IW'(MAXE);
		start <= 1'b0;
		op <= OP_LOAD;
		element_index <= '0;
		element_key <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes of keys, ties, every status code.
		write_count(8);
		send_item(OP_EXTRACT, 0, 0);
		send_item(OP_LOAD, 0, 5);
		send_item(OP_LOAD, 9, 5);
		send_item(OP_LOAD, 1, 32'sh7fffffff);
		send_item(OP_LOAD, 2, 32'sh80000000);
		send_item(OP_LOAD, 3, 0);
		send_item(OP_LOAD, 4, -1);
		send_item(OP_LOAD, 5, 0);
		send_item(OP_LOAD, 6, 1);
		send_item(OP_LOAD, 7, 32'sh80000000);
		send_item(OP_LOAD, 8, 32'sh7fffffff);
		send_item(OP_BUILD, 0, 0);
		send_item(OP_LOAD, 3, 77);
		send_item(OP_INSERT, 3, 77);
		send_item(OP_INSERT, MAXE, 1);
		repeat (8) send_item(OP_EXTRACT, 0, 0);
		send_item(OP_EXTRACT, 0, 0);
		send_item(OP_INSERT, 5, 32'sh80000000);
		send_item(OP_EXTRACT, 0, 0);
		drain();
		write_count(0);
		send_item(OP_BUILD, 0, 0);
		send_item(OP_INSERT, 1, 3);
		drain();
		write_count(2047);
		send_item(OP_INSERT, MAXE, -7);
		send_item(OP_EXTRACT, 0, 0);
		drain();

		// Random phases, each under one element count.
		sel = 0;
		while (items_sent < ITEM_GOAL) begin
			roll = $urandom_range(99);
			if (sel == 2 || sel == 9)
				write_count((sel == 2) ? MAXE : 2047);
			else if (roll < 5)
				write_count($urandom_range(1) ? 0 : 1);
			else if (roll < 10)
				write_count($urandom_range(1000, 2047));
			else
				write_count($urandom_range(1, 40));
			idle_enabled = (sel != 4);
			span = $urandom_range(60, 150);
			repeat (span) begin
				roll = $urandom_range(99);
				if (roll < 38)
					send_item(OP_INSERT, pick_index(), pick_key());
				else if (roll < 76)
					send_item(OP_EXTRACT, $urandom_range(0, MAXE), pick_key());
				else if (roll < 92)
					send_item(OP_LOAD, pick_index(), pick_key());
				else if (usable_count() <= 64 || sel == 2 || sel == 9)
					build_safe();
				else
					send_item(OP_EXTRACT, 0, 0);
			end
			drain();
			sel++;
		end

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
